// ===== sv/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// Date/time to seconds package
// Shared field types, widths, calendar constants and the day-of-year table
// for the date/time to seconds converter.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Field widths of one input item.
    localparam int YEAR_W    = 8;
    localparam int MONTH_W   = 8;
    localparam int DAY_W     = 8;
    localparam int WEEKDAY_W = 4;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    // Field widths of one result item.
    localparam int SECONDS_W = 32;

    // Internal widths, sized to the largest values they carry.
    localparam int DOY_W   = 9;   // day of year, up to 365
    localparam int YDAYS_W = 16;  // year * 365 for years below 128
    localparam int LEAPS_W = 5;   // leap days of past years, up to 25 for years below 100
    localparam int DAYS_W  = 16;  // total day count, up to 36525
    localparam int HM_W    = 11;  // hour * 60 + minute, up to 1923
    localparam int TOD_W   = 17;  // seconds into the day, up to 115443

    // Range limits of the date check.
    localparam logic [YEAR_W-1:0]    YEAR_LIMIT    = 8'd100;
    localparam logic [MONTH_W-1:0]   MONTH_MAX     = 8'd12;
    localparam logic [DAY_W-1:0]     DAY_MAX       = 8'd31;
    localparam logic [WEEKDAY_W-1:0] WEEKDAY_LIMIT = 4'd7;

    // Calendar scale factors.
    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
    localparam logic [5:0]  SIXTY           = 6'd60;

    // One input item, unpacked.
    typedef struct packed {
        logic [SECOND_W-1:0]  second;
        logic [MINUTE_W-1:0]  minute;
        logic [HOUR_W-1:0]    hour;
        logic [WEEKDAY_W-1:0] weekday;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } date_time_t;

    // Partial result leaving the calculation pipeline.
    typedef struct packed {
        logic                 invalid;
        logic [SECONDS_W-1:0] day_seconds;
        logic [TOD_W-1:0]     tod;
    } dts_part_t;

    // Days before the first of a month in a common year, indexed by month - 1.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] idx);
        logic [DOY_W-1:0] val;
        case (idx)
            4'd0:    val = 9'd0;
            4'd1:    val = 9'd31;
            4'd2:    val = 9'd59;
            4'd3:    val = 9'd90;
            4'd4:    val = 9'd120;
            4'd5:    val = 9'd151;
            4'd6:    val = 9'd181;
            4'd7:    val = 9'd212;
            4'd8:    val = 9'd243;
            4'd9:    val = 9'd273;
            4'd10:   val = 9'd304;
            4'd11:   val = 9'd334;
            default: val = 9'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/dts_calc.sv =====
// ----------------------------------------------------------------------------
// Date/time to seconds calculation pipeline
// Three register stages: date check and partial day count, day and time
// sums, scaling of the day count to seconds. Each stage carries a valid bit
// and holds while the stage after it is full and stalled.
// ----------------------------------------------------------------------------
module dts_calc (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dts_pkg::date_time_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output dts_pkg::dts_part_t out_part
);
    import dts_pkg::*;

    // Stage valid bits and per-stage advance conditions.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1 payload.
    logic                inv1_reg, inv1_next;
    logic [DOY_W-1:0]    doy1_reg, doy1_next;
    logic [YDAYS_W-1:0]  ydays1_reg, ydays1_next;
    logic [LEAPS_W-1:0]  leaps1_reg, leaps1_next;
    logic [HM_W-1:0]     hm1_reg, hm1_next;
    logic [SECOND_W-1:0] sec1_reg;

    // Stage 2 payload.
    logic                inv2_reg;
    logic [DAYS_W-1:0]   days2_reg, days2_next;
    logic [TOD_W-1:0]    tod2_reg, tod2_next;

    // Stage 3 payload.
    logic                 inv3_reg;
    logic [SECONDS_W-1:0] dsec3_reg, dsec3_next;
    logic [TOD_W-1:0]     tod3_reg;

    logic [3:0] month_idx;
    logic [6:0] year_lo;
    logic       leap_adj;

    // Stage 1: range check, day of year, year terms and hour/minute.
    always_comb begin
        inv1_next = (in_item.year >= YEAR_LIMIT)
                 || (in_item.month == '0) || (in_item.month > MONTH_MAX)
                 || (in_item.day == '0) || (in_item.day > DAY_MAX)
                 || (in_item.weekday >= WEEKDAY_LIMIT);
        // Only meaningful for a valid month; an invalid item is zeroed later.
        month_idx = in_item.month[3:0] - 4'd1;
        year_lo   = in_item.year[6:0];
        leap_adj  = (in_item.month >= 8'd3) && (in_item.year[1:0] == 2'b00);
        doy1_next = DOY_W'(in_item.day[4:0]) - DOY_W'(1)
                  + days_before_month(month_idx) + DOY_W'(leap_adj);
        ydays1_next = YDAYS_W'(year_lo) * YDAYS_W'(DAYS_PER_YEAR);
        leaps1_next = LEAPS_W'((8'(year_lo) + 8'd3) >> 2);
        hm1_next    = HM_W'(in_item.hour) * HM_W'(SIXTY) + HM_W'(in_item.minute);
    end

    // Stage 2: full day count and seconds into the day.
    always_comb begin
        days2_next = DAYS_W'(doy1_reg) + ydays1_reg + DAYS_W'(leaps1_reg);
        tod2_next  = TOD_W'(hm1_reg) * TOD_W'(SIXTY) + TOD_W'(sec1_reg);
    end

    // Stage 3: day count scaled to seconds.
    always_comb begin
        dsec3_next = SECONDS_W'(days2_reg) * SECONDS_W'(SECONDS_PER_DAY);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            inv1_reg   <= inv1_next;
            doy1_reg   <= doy1_next;
            ydays1_reg <= ydays1_next;
            leaps1_reg <= leaps1_next;
            hm1_reg    <= hm1_next;
            sec1_reg   <= in_item.second;
        end
        if (rdy2) begin
            inv2_reg  <= inv1_reg;
            days2_reg <= days2_next;
            tod2_reg  <= tod2_next;
        end
        if (rdy3) begin
            inv3_reg  <= inv2_reg;
            dsec3_reg <= dsec3_next;
            tod3_reg  <= tod2_reg;
        end
    end

    assign out_valid            = v3_reg;
    assign out_part.invalid     = inv3_reg;
    assign out_part.day_seconds = dsec3_reg;
    assign out_part.tod         = tod3_reg;

endmodule

// ===== sv/date_time_to_seconds.sv =====
// ----------------------------------------------------------------------------
// Date/time to seconds converter
// Converts a calendar date and time of day to seconds since 2000-01-01.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ stream; every transfer carries one date and
// time. Each accepted item gives exactly one result on the m_ stream: the
// seconds since the start of year 2000 in m_tdata, and m_tuser high when the
// date failed its range check (year 100 or more, month outside 1 to 12, day
// outside 1 to 31, weekday 7 or more), in which case m_tdata is zero.
// The time fields are not checked.
// The input transfer reaches m_tvalid through three calculation stages and
// the output register. One item is accepted every cycle while the receiver
// takes every result; the rate is set by the four-stage pipeline, whose
// longest step is the 16 by 17 bit multiplication of the day count.
// When the receiver stalls, the stages fill up and s_tready drops once all
// four are occupied; nothing is lost or repeated. Reset empties the pipeline
// and clears m_tvalid.
// ----------------------------------------------------------------------------
module date_time_to_seconds (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[7:0], month[15:8], day[23:16], weekday[27:24], hour[32:28],
    // minute[38:33], second[44:39], zero fill[47:45]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // seconds[31:0]
    output logic [31:0] m_tdata,
    // invalid[0]
    output logic        m_tuser
);
    import dts_pkg::*;

    date_time_t item;
    dts_part_t  part;
    logic       part_valid;
    logic       out_rdy;

    logic                 v4_reg;
    logic [SECONDS_W-1:0] sec4_reg, sec4_next;
    logic                 inv4_reg;

    // Unpack the input transfer.
    assign item.year    = s_tdata[7:0];
    assign item.month   = s_tdata[15:8];
    assign item.day     = s_tdata[23:16];
    assign item.weekday = s_tdata[27:24];
    assign item.hour    = s_tdata[32:28];
    assign item.minute  = s_tdata[38:33];
    assign item.second  = s_tdata[44:39];

    dts_calc u_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (part_valid),
        .out_ready (out_rdy),
        .out_part  (part)
    );

    // Final stage: add the time of day, force zero for a rejected date.
    assign out_rdy = !v4_reg || m_tready;

    always_comb begin
        sec4_next = part.invalid ? '0
                  : part.day_seconds + SECONDS_W'(part.tod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (out_rdy) begin
            v4_reg <= part_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            sec4_reg <= sec4_next;
            inv4_reg <= part.invalid;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = sec4_reg;
    assign m_tuser  = inv4_reg;

endmodule
